### rtl/msbbp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msbbp_pkg
// Shared types and constants for the MSB-first bit packer.
// ---------------------------------------------------------------------------
package msbbp_pkg;

  localparam int CODE_W                = 64;
  localparam int COUNT_W               = 7;
  localparam int BYTE_W                = 8;
  localparam int FILL_W                = 3;
  localparam int PART_W                = 7;
  localparam int BUF_W                 = CODE_W + BYTE_W;
  localparam int LEFT_W                = 4;
  localparam int DEFAULT_MAX_CODE_BITS = 64;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cmd_t;

  typedef struct packed {
    logic has_bytes;
    logic last;
    logic pending;
  } status_t;

endpackage

### rtl/msbbp_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msbbp_datapath
// Aligns the partial byte and the code into a byte buffer, shifts out one
// byte per advance and keeps the leftover bits for the next request.
// ---------------------------------------------------------------------------
module msbbp_datapath #(
  parameter int MAX_CODE_BITS = msbbp_pkg::DEFAULT_MAX_CODE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_operation,
  input  logic [msbbp_pkg::CODE_W-1:0]        in_code,
  input  logic [msbbp_pkg::COUNT_W-1:0]       in_bit_count,
  input  msbbp_pkg::cmd_t                     cmd,
  output msbbp_pkg::status_t                  sts,
  output logic [msbbp_pkg::BYTE_W-1:0]        out_byte,
  output logic                                out_run_last
);
  import msbbp_pkg::*;

  localparam logic [COUNT_W-1:0] MaxBits = COUNT_W'(MAX_CODE_BITS);

  logic [BUF_W-1:0]   buf_r,        buf_nxt;
  logic [LEFT_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic [PART_W-1:0]  partial_r,    partial_nxt;
  logic [FILL_W-1:0]  fill_r,       fill_nxt;

  logic [COUNT_W-1:0] n_sat;
  logic [COUNT_W-1:0] total;
  logic [CODE_W-1:0]  code_al;
  logic [BYTE_W-1:0]  ptop;
  logic [PART_W-1:0]  pshift;
  logic [PART_W-1:0]  nmask;
  logic [PART_W-1:0]  fmask;
  logic [BUF_W-1:0]   app_buf;
  logic [PART_W-1:0]  app_partial;
  logic [LEFT_W-1:0]  load_bytes;

  always_comb begin
    n_sat   = (in_bit_count > MaxBits) ? MaxBits : in_bit_count;
    total   = COUNT_W'(fill_r) + n_sat;
    code_al = in_code << (COUNT_W'(CODE_W) - n_sat);
    ptop    = BYTE_W'({1'b0, partial_r} << (LEFT_W'(BYTE_W) - LEFT_W'(fill_r)));
    app_buf = ({code_al, {BYTE_W{1'b0}}} >> fill_r) | {ptop, {CODE_W{1'b0}}};
    pshift  = PART_W'({{PART_W{1'b0}}, partial_r} << n_sat);
    nmask   = (n_sat >= COUNT_W'(PART_W)) ? {PART_W{1'b1}}
                                          : ({PART_W{1'b1}} >> (3'd7 - n_sat[2:0]));
    fmask   = {PART_W{1'b1}} >> (3'd7 - total[2:0]);
    app_partial = (pshift | (in_code[PART_W-1:0] & nmask)) & fmask;
    if (in_operation == OP_FLUSH) begin
      load_bytes = (fill_r != '0) ? LEFT_W'(1) : '0;
    end else begin
      load_bytes = total[COUNT_W-1:FILL_W];
    end
  end

  always_comb begin
    buf_nxt        = buf_r;
    bytes_left_nxt = bytes_left_r;
    partial_nxt    = partial_r;
    fill_nxt       = fill_r;
    if (cmd.load) begin
      bytes_left_nxt = load_bytes;
      if (in_operation == OP_FLUSH) begin
        buf_nxt     = {ptop, {CODE_W{1'b0}}};
        partial_nxt = '0;
        fill_nxt    = '0;
      end else begin
        buf_nxt     = app_buf;
        partial_nxt = app_partial;
        fill_nxt    = total[FILL_W-1:0];
      end
    end else if (cmd.shift) begin
      buf_nxt        = buf_r << BYTE_W;
      bytes_left_nxt = bytes_left_r - LEFT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      partial_r    <= '0;
      fill_r       <= '0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      partial_r    <= partial_nxt;
      fill_r       <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  assign sts.has_bytes = (load_bytes != '0);
  assign sts.last      = (bytes_left_r == LEFT_W'(1));
  assign sts.pending   = (bytes_left_r != '0);
  assign out_byte      = buf_r[BUF_W-1 -: BYTE_W];
  assign out_run_last  = sts.last;

endmodule

### rtl/msbbp_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msbbp_ctrl
// Sequencer: takes one request while idle, then hands out its bytes.
// ---------------------------------------------------------------------------
module msbbp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  msbbp_pkg::status_t sts,
  output msbbp_pkg::cmd_t    cmd
);
  import msbbp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.has_bytes) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.shift = 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/msb_first_bit_packer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msb_first_bit_packer
// Packs codes of 0 to MAX_CODE_BITS bits MSB-first into a byte stream.
// Latency: the first byte of a request is valid the cycle after it is taken.
// Throughput: one byte per cycle from the shift buffer while out_stall is
// low; a new request is taken only once all bytes of the last one are out.
// Reset (rst_n low, synchronous) clears the partial byte, fill count and state.
// ---------------------------------------------------------------------------
module msb_first_bit_packer #(
  parameter int MAX_CODE_BITS = msbbp_pkg::DEFAULT_MAX_CODE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [msbbp_pkg::CODE_W-1:0]  in_code,
  input  logic [msbbp_pkg::COUNT_W-1:0] in_bit_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [msbbp_pkg::BYTE_W-1:0]  out_out_byte,
  output logic                          out_run_last
);
  import msbbp_pkg::*;

  cmd_t    cmd;
  status_t sts;

  msbbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  msbbp_datapath #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_operation),
    .in_code      (in_code),
    .in_bit_count (in_bit_count),
    .cmd          (cmd),
    .sts          (sts),
    .out_byte     (out_out_byte),
    .out_run_last (out_run_last)
  );

  a_no_take_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !out_valid)
    else $error("request taken while bytes pending");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_run_last) |=> !out_valid)
    else $error("output continues after last byte");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_run_last) |=> (out_valid && in_stall))
    else $error("run ended without last marker");

  a_valid_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sts.pending)
    else $error("output valid with empty buffer");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MSB-first bit packer testbench
// Drives append and flush requests through the valid/stall input channel and
// checks each output byte and its run_last flag against bytes typed in the
// directed table, or else a bit-level packer model kept in the testbench.
// The table covers empty writes, byte fills, full 64-bit codes, length
// saturation and flushes. Random traffic follows, with bursty requests, a
// patterned output stall, one long output hold-off and one full drain pause.
// ---------------------------------------------------------------------------
module testbench;
  import msbbp_pkg::*;

  localparam int CODE_BITS_MAX = DEFAULT_MAX_CODE_BITS;
  localparam int RANDOM_REQS   = 388;
  localparam int PAUSE_AT      = 250;
  localparam int HOLD_AT       = 120;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int N_ROWS        = 22;
  localparam logic TYPED       = 1'b1;
  localparam logic PREDICTED   = 1'b0;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } byte_exp_t;

  typedef struct packed {
    logic               op;
    logic [CODE_W-1:0]  code;
    logic [COUNT_W-1:0] count;
    logic               typed;
    logic [3:0]         n;
    logic [CODE_W-1:0]  bytes;
  } row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_operation;
  logic [CODE_W-1:0]   in_code;
  logic [COUNT_W-1:0]  in_bit_count;
  logic                out_valid;
  logic                out_stall;
  logic [BYTE_W-1:0]   out_out_byte;
  logic                out_run_last;

  byte_exp_t           packed_bytes_q[$];
  byte_exp_t           head;
  logic [PART_W-1:0]   pend_bits;
  logic [FILL_W-1:0]   pend_fill;
  int                  error_count;
  int                  taken_count;
  int                  flush_count;
  int                  bytes_checked;
  int                  idle_cycles;

  row_t directed_rows [N_ROWS] = '{
    '{OP_FLUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd64,  TYPED, 4'd0, 64'h0},
    '{OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0,   TYPED, 4'd0, 64'h0},
    '{OP_APPEND, 64'h0000_0000_0000_00A5, 7'd8,   TYPED, 4'd1, 64'hA500_0000_0000_0000},
    '{OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64,  TYPED, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF},
    '{OP_APPEND, 64'h0000_0000_0000_0000, 7'd64,  TYPED, 4'd8, 64'h0000_0000_0000_0000},
    '{OP_APPEND, 64'h0000_0000_0000_0001, 7'd1,   TYPED, 4'd0, 64'h0},
    '{OP_FLUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd127, TYPED, 4'd1, 64'h8000_0000_0000_0000},
    '{OP_APPEND, 64'h0123_4567_89AB_CDEF, 7'd127, TYPED, 4'd8, 64'h0123_4567_89AB_CDEF},
    '{OP_APPEND, 64'hFFFF_FFFF_FFFF_FF00, 7'd8,   TYPED, 4'd1, 64'h0},
    '{OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFD, 7'd3,   TYPED, 4'd0, 64'h0},
    '{OP_FLUSH,  64'h0000_0000_0000_0000, 7'd0,   TYPED, 4'd1, 64'hA000_0000_0000_0000},
    '{OP_APPEND, 64'h0000_0000_0000_007F, 7'd7,   TYPED, 4'd0, 64'h0},
    '{OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFE, 7'd1,   TYPED, 4'd1, 64'hFE00_0000_0000_0000},
    '{OP_APPEND, 64'h0000_0000_0000_000A, 7'd4,   TYPED, 4'd0, 64'h0},
    '{OP_APPEND, 64'h0000_0000_0000_0005, 7'd4,   TYPED, 4'd1, 64'hA500_0000_0000_0000},
    '{OP_APPEND, 64'h8000_0000_0000_0001, 7'd64,  TYPED, 4'd8, 64'h8000_0000_0000_0001},
    '{OP_APPEND, 64'h0000_0000_0000_0015, 7'd5,   PREDICTED, 4'd0, 64'h0},
    '{OP_APPEND, 64'hDEAD_BEEF_CAFE_F00D, 7'd64,  PREDICTED, 4'd0, 64'h0},
    '{OP_APPEND, 64'h0000_0000_0000_0003, 7'd2,   PREDICTED, 4'd0, 64'h0},
    '{OP_APPEND, 64'h5A5A_5A5A_A5A5_A5A5, 7'd65,  PREDICTED, 4'd0, 64'h0},
    '{OP_FLUSH,  64'h1234_5678_9ABC_DEF0, 7'd33,  PREDICTED, 4'd0, 64'h0},
    '{OP_FLUSH,  64'h0000_0000_0000_0000, 7'd0,   TYPED, 4'd0, 64'h0}
  };

  msb_first_bit_packer #(
    .MAX_CODE_BITS(CODE_BITS_MAX)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_code      (in_code),
    .in_bit_count (in_bit_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_out_byte (out_out_byte),
    .out_run_last (out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // advance the packer state; queue the bytes unless the row supplies them
  function automatic void pack_request(input logic op, input logic [CODE_W-1:0] code,
                                       input logic [COUNT_W-1:0] count, input logic record);
    logic [BYTE_W-1:0] made [9];
    logic [BYTE_W-1:0] acc;
    byte_exp_t         e;
    int                fill;
    int                nbits;
    int                produced;
    produced = 0;
    if (op == OP_FLUSH) begin
      if (pend_fill != 0) begin
        made[0] = {1'b0, pend_bits} << (BYTE_W - pend_fill);
        produced = 1;
      end
      pend_bits = '0;
      pend_fill = '0;
    end else begin
      nbits = (count > CODE_BITS_MAX) ? CODE_BITS_MAX : int'(count);
      acc = {1'b0, pend_bits};
      fill = int'(pend_fill);
      for (int i = nbits; i > 0; i--) begin
        acc = {acc[BYTE_W-2:0], code[i-1]};
        fill++;
        if (fill == BYTE_W) begin
          made[produced] = acc;
          produced++;
          acc = '0;
          fill = 0;
        end
      end
      pend_bits = acc[PART_W-1:0];
      pend_fill = fill[FILL_W-1:0];
    end
    if (record) begin
      for (int k = 0; k < produced; k++) begin
        e.value = made[k];
        e.last = (k == produced - 1);
        packed_bytes_q.push_back(e);
      end
    end
  endfunction

  task automatic offer(input logic op, input logic [CODE_W-1:0] code,
                       input logic [COUNT_W-1:0] count, input logic record);
    in_valid <= 1'b1;
    in_operation <= op;
    in_code <= code;
    in_bit_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pack_request(op, code, count, record);
    taken_count++;
    if (op == OP_FLUSH) flush_count++;
  endtask

  initial begin
    row_t                row;
    byte_exp_t           e;
    logic                op;
    logic [CODE_W-1:0]   code;
    logic [COUNT_W-1:0]  count;
    int                  idx;
    int                  burst;
    int                  gap;
    int                  pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_APPEND;
    in_code = '0;
    in_bit_count = '0;
    pend_bits = '0;
    pend_fill = '0;
    error_count = 0;
    taken_count = 0;
    flush_count = 0;
    bytes_checked = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      row = directed_rows[r];
      offer(row.op, row.code, row.count, !row.typed);
      if (row.typed) begin
        for (int k = 0; k < row.n; k++) begin
          e.value = row.bytes[CODE_W-1-BYTE_W*k -: BYTE_W];
          e.last = (k == row.n - 1);
          packed_bytes_q.push_back(e);
        end
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    idx = 0;
    while (idx < RANDOM_REQS) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
      for (int k = 0; k < burst && idx < RANDOM_REQS; k++) begin
        if (idx == PAUSE_AT) begin
          // drain: hold requests until every byte is out
          in_valid <= 1'b0;
          @(posedge clk);
          while (packed_bytes_q.size() != 0) @(posedge clk);
        end
        op = ($urandom_range(0, 9) == 0) ? OP_FLUSH : OP_APPEND;
        code = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 60) count = COUNT_W'($urandom_range(1, 12));
        else if (pick < 80) count = COUNT_W'($urandom_range(13, 64));
        else if (pick < 88) count = 7'd64;
        else if (pick < 94) count = 7'd0;
        else count = COUNT_W'($urandom_range(65, 127));
        offer(op, code, count, 1'b1);
        idx++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (packed_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d flushes) and %0d checked bytes,", taken_count,
             flush_count, bytes_checked);
    $display("with bursty input, patterned output stalls, a long hold-off and a drain pause.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // output stall pattern, with one long hold-off once traffic is flowing
  initial begin
    int  mode;
    int  stretch;
    int  hold_left;
    bit  hold_done;
    out_stall = 1'b0;
    mode = 0;
    stretch = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && taken_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 3);
          stretch = $urandom_range(10, 60);
        end
        stretch--;
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && !out_stall) begin
        if (packed_bytes_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected byte: expected none, actual %02h last %0b", $time,
                   out_out_byte, out_run_last);
        end else begin
          head = packed_bytes_q.pop_front();
          bytes_checked++;
          if (out_out_byte !== head.value) begin
            error_count++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h", $time,
                     head.value, out_out_byte);
          end
          if (out_run_last !== head.last) begin
            error_count++;
            $display("%0t: run_last mismatch: expected %0b, actual %0b", $time,
                     head.last, out_run_last);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no request accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

endmodule

### msb_first_bit_packer.f
rtl/msbbp_pkg.sv
rtl/msbbp_datapath.sv
rtl/msbbp_ctrl.sv
rtl/msb_first_bit_packer.sv
verif/testbench.sv
